// ----- rtl/core/mlcd_pkg.sv -----
package mlcd_pkg;

	localparam int FrameBytesDef = 1024;
	localparam int RowColumnsDef = 128;
	localparam int PageCountDef = 8;

	localparam logic [7:0] CMD_COLUMN = 8'h40;
	localparam logic [7:0] CMD_PAGE = 8'hB8;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h3F;

	typedef enum logic [2:0] {
		REQ_SET_PIXEL = 3'd0,
		REQ_READ_PIXEL = 3'd1,
		REQ_FILL = 3'd2,
		REQ_INVERT = 3'd3,
		REQ_REFRESH = 3'd4,
		REQ_POLL = 3'd5,
		REQ_NOP6 = 3'd6,
		REQ_NOP7 = 3'd7
	} req_t;

	typedef struct packed {
		req_t req;
		logic [6:0] pixel_x;
		logic [5:0] pixel_y;
		logic [7:0] write_value;
		logic [2:0] page_row;
	} cmd_t;

	typedef struct packed {
		logic bus_valid;
		logic to_right;
		logic is_data;
		logic [7:0] bus_byte;
		logic frame_last;
		logic pixel_bit;
		logic was_dirty;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MODIFY,
		ST_SWEEP_RD,
		ST_SWEEP_WR,
		ST_CLEAR,
		ST_RESULT
	} bstate_t;

endpackage

// ----- rtl/core/mlcd_front.sv -----
module mlcd_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] req_type,
	input logic [6:0] pixel_x,
	input logic [5:0] pixel_y,
	input logic [7:0] write_value,
	input logic [2:0] page_row,
	output logic cmd_valid,
	output mlcd_pkg::cmd_t cmd,
	input logic cmd_take
);
	import mlcd_pkg::*;

	cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic do_push, do_pop;

	assign full = cnt_q == 2'd2;
	assign do_push = push && !full;
	assign do_pop = cmd_take && cnt_q != 2'd0;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wp_q] <= '{req: req_t'(req_type), pixel_x: pixel_x, pixel_y: pixel_y,
				write_value: write_value, page_row: page_row};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ----- rtl/core/mlcd_back.sv -----
module mlcd_back #(
	parameter int ROW_COLUMNS = mlcd_pkg::RowColumnsDef,
	parameter int PAGE_COUNT = mlcd_pkg::PageCountDef
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input mlcd_pkg::cmd_t cmd,
	output logic cmd_take,
	output logic empty,
	input logic pop,
	output mlcd_pkg::res_t res,
	output logic busy
);
	import mlcd_pkg::*;

	localparam int FRAME_BYTES = FrameBytesDef;
	localparam int AW = $clog2(FRAME_BYTES);
	localparam int CW = $clog2(ROW_COLUMNS);
	localparam int HALF = ROW_COLUMNS / 2;
	localparam int PSTEPS = ROW_COLUMNS + 4;
	localparam int FSTEPS = PAGE_COUNT * PSTEPS + 5;
	localparam int SW = $clog2(FSTEPS);
	localparam int PW = $clog2(PAGE_COUNT);
	localparam int STW = $clog2(PSTEPS);

	logic [7:0] mem [FRAME_BYTES];
	logic [7:0] rd_q;
	logic [AW-1:0] raddr, waddr;
	logic re, we;
	logic [7:0] wdata;

	bstate_t st_q, st_d;
	cmd_t c_q;
	logic [AW:0] idx_q, idx_d;
	logic dirty_q, dirty_d;
	res_t out_q, out_d;
	logic full_q, full_d;
	logic [SW-1:0] pos_q, pos_d;
	logic [PW-1:0] spage_q, spage_d;
	logic [STW-1:0] sstep_q, sstep_d;
	logic take;
	logic [AW-1:0] pix_addr, row_addr, scan_addr;
	logic [AW+8:0] pa_full, ra_full;
	logic [STW-1:0] s_adj;
	logic s_right;
	logic [CW:0] col;
	logic [7:0] mask;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	assign pa_full = (AW+9)'(c_q.pixel_y[5:3]) * (AW+9)'(ROW_COLUMNS)
		+ (AW+9)'(c_q.pixel_x);
	assign pix_addr = pa_full[AW-1:0];
	assign ra_full = (AW+9)'(c_q.page_row) * (AW+9)'(ROW_COLUMNS) + (AW+9)'(idx_q);
	assign row_addr = ra_full[AW-1:0];
	assign mask = 8'(1) << c_q.pixel_y[2:0];

	always_comb begin
		s_right = 1'b1;
		s_adj = sstep_q;
		if (sstep_q >= STW'(2 + HALF)) begin
			s_right = 1'b0;
			s_adj = sstep_q - STW'(2 + HALF);
		end
		col = (CW+1)'(s_adj - STW'(2)) + (s_right ? '0 : (CW+1)'(HALF));
		scan_addr = AW'(FRAME_BYTES - 1) - AW'((AW+9)'(spage_q) * (AW+9)'(ROW_COLUMNS)
			+ (AW+9)'(col));
	end

	assign busy = st_q != ST_IDLE;
	assign take = st_q == ST_IDLE && cmd_valid && !full_q;
	assign cmd_take = take;
	assign empty = !full_q;
	assign res = out_q;

	always_comb begin
		st_d = st_q;
		idx_d = idx_q;
		dirty_d = dirty_q;
		out_d = out_q;
		full_d = full_q && !pop;
		pos_d = pos_q;
		spage_d = spage_q;
		sstep_d = sstep_q;
		re = 1'b0;
		we = 1'b0;
		raddr = pix_addr;
		waddr = pix_addr;
		wdata = rd_q;
		case (st_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = idx_q[AW-1:0];
				wdata = '0;
				idx_d = idx_q + 1'b1;
				if (idx_q == (AW+1)'(FRAME_BYTES - 1)) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take) begin
					st_d = ST_READ;
					idx_d = '0;
				end
			end
			ST_READ: begin
				out_d = '0;
				st_d = ST_RESULT;
				case (c_q.req)
					REQ_SET_PIXEL, REQ_READ_PIXEL: begin
						re = 1'b1;
						st_d = ST_MODIFY;
					end
					REQ_FILL: begin
						we = 1'b1;
						waddr = idx_q[AW-1:0];
						wdata = c_q.write_value;
						dirty_d = 1'b1;
						idx_d = idx_q + 1'b1;
						if (idx_q != (AW+1)'(FRAME_BYTES - 1)) st_d = ST_READ;
					end
					REQ_INVERT: begin
						re = 1'b1;
						raddr = row_addr;
						st_d = ST_SWEEP_WR;
					end
					REQ_REFRESH: begin
						if (pos_q < SW'(PAGE_COUNT * PSTEPS)) begin
							out_d.bus_valid = 1'b1;
							out_d.to_right = s_right;
							if (s_adj == '0) begin
								out_d.bus_byte = CMD_COLUMN;
								st_d = ST_RESULT;
							end else if (s_adj == STW'(1)) begin
								out_d.bus_byte = CMD_PAGE | 8'(spage_q);
								st_d = ST_RESULT;
							end else begin
								out_d.is_data = 1'b1;
								re = 1'b1;
								raddr = scan_addr;
								st_d = ST_SWEEP_RD;
							end
							pos_d = pos_q + 1'b1;
							if (sstep_q == STW'(PSTEPS - 1)) begin
								sstep_d = '0;
								spage_d = spage_q + 1'b1;
							end else begin
								sstep_d = sstep_q + 1'b1;
							end
						end else begin
							out_d.bus_valid = 1'b1;
							pos_d = pos_q + 1'b1;
							case (pos_q - SW'(PAGE_COUNT * PSTEPS))
								SW'(0): out_d.bus_byte = CMD_PAGE;
								SW'(1): begin
									out_d.to_right = 1'b1;
									out_d.bus_byte = CMD_PAGE;
								end
								SW'(2): out_d.bus_byte = CMD_COLUMN;
								SW'(3): begin
									out_d.to_right = 1'b1;
									out_d.bus_byte = CMD_DISPLAY_ON;
								end
								default: begin
									out_d.bus_byte = CMD_DISPLAY_ON;
									out_d.frame_last = 1'b1;
									pos_d = '0;
									spage_d = '0;
									sstep_d = '0;
								end
							endcase
						end
					end
					REQ_POLL: begin
						out_d.was_dirty = dirty_q;
						dirty_d = 1'b0;
					end
					default: ;
				endcase
			end
			ST_MODIFY: begin
				st_d = ST_RESULT;
				if (c_q.req == REQ_SET_PIXEL) begin
					we = 1'b1;
					wdata = (c_q.write_value != '0) ? (rd_q | mask) : (rd_q & ~mask);
					dirty_d = 1'b1;
				end else begin
					out_d.pixel_bit = |(rd_q & mask);
				end
			end
			ST_SWEEP_WR: begin
				we = 1'b1;
				waddr = row_addr;
				wdata = ~rd_q;
				idx_d = idx_q + 1'b1;
				st_d = (idx_q == (AW+1)'(ROW_COLUMNS - 1)) ? ST_RESULT : ST_READ;
			end
			ST_SWEEP_RD: begin
				out_d.bus_byte = rd_q;
				st_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!full_q) begin
					full_d = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) c_q <= cmd;
		out_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			idx_q <= '0;
			dirty_q <= 1'b0;
			full_q <= 1'b0;
			pos_q <= '0;
			spage_q <= '0;
			sstep_q <= '0;
		end else begin
			st_q <= st_d;
			idx_q <= idx_d;
			dirty_q <= dirty_d;
			full_q <= full_d;
			pos_q <= pos_d;
			spage_q <= spage_d;
			sstep_q <= sstep_d;
		end
	end

endmodule

// ----- rtl/core/mono_lcd_frame_buffer_scanner_core.sv -----
// Channel   Handshake          Words
// request   push / full        req_type, pixel_x, pixel_y, write_value, page_row
// result    pop / empty        bus_valid, to_right, is_data, bus_byte, frame_last,
//                              pixel_bit, was_dirty
// Pixel requests read the store and then modify it; poll needs no store access and refresh reads one byte at most.
// Fill writes every byte and page inversion reads and rewrites each column of one page, one byte at a time, one store.
// After reset the store is cleared byte by byte; requests queue meanwhile.
// A two-word request queue lets pushes continue while a result waits to be popped.
// The back end stalls only on a result still waiting in the output register.
module mono_lcd_frame_buffer_scanner_core #(
	parameter int ROW_COLUMNS = mlcd_pkg::RowColumnsDef,
	parameter int PAGE_COUNT = mlcd_pkg::PageCountDef
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] req_type,
	input logic [6:0] pixel_x,
	input logic [5:0] pixel_y,
	input logic [7:0] write_value,
	input logic [2:0] page_row,
	output logic empty,
	input logic pop,
	output logic bus_valid,
	output logic to_right,
	output logic is_data,
	output logic [7:0] bus_byte,
	output logic frame_last,
	output logic pixel_bit,
	output logic was_dirty
);
	import mlcd_pkg::*;

	logic cmd_valid, cmd_take, busy;
	cmd_t cmd;
	res_t res;

	mlcd_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req_type(req_type),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .write_value(write_value),
		.page_row(page_row), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	mlcd_back #(
		.ROW_COLUMNS(ROW_COLUMNS), .PAGE_COUNT(PAGE_COUNT)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .empty(empty), .pop(pop), .res(res), .busy(busy)
	);

	assign bus_valid = res.bus_valid;
	assign to_right = res.to_right;
	assign is_data = res.is_data;
	assign bus_byte = res.bus_byte;
	assign frame_last = res.frame_last;
	assign pixel_bit = res.pixel_bit;
	assign was_dirty = res.was_dirty;

`ifndef SYNTH
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("take without queued word");
	a_last_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_last) |-> (bus_valid && !is_data && !to_right))
		else $error("frame end on bad write");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && bus_valid) |-> (!pixel_bit && !was_dirty))
		else $error("mixed result kinds");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> busy) else $error("back end not busy after take");
`endif

endmodule
